[rtl/ims_pkg.sv]
// ims_pkg: shared types and constants for the i2c master bit sequencer
// holds the command codes, the sequencer state record and the result record
// no dependencies
package ims_pkg;

    // fixed field widths
    localparam int DATA_BITS   = 8;
    localparam int ADDR_BITS   = 7;
    localparam int KIND_W      = 3;
    localparam int PHASE_W     = 16;
    localparam int HOLD_W      = 8;
    localparam int STEP_W      = 2;
    localparam int BIT_IDX_W   = 4;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 16;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_TICKS   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RW_HOLD_TICKS = 1'd1;

    // configuration reset values
    localparam logic [PHASE_W-1:0] PHASE_TICKS_RESET   = 16'd1;
    localparam logic [HOLD_W-1:0]  RW_HOLD_TICKS_RESET = 8'd4;

    // request kinds; idle shares the tick code as the active command
    typedef enum logic [KIND_W-1:0] {
        KIND_TICK   = 3'd0,
        KIND_START  = 3'd1,
        KIND_STOP   = 3'd2,
        KIND_WBYTE  = 3'd3,
        KIND_WADDR  = 3'd4,
        KIND_CHECK  = 3'd5,
        KIND_READ   = 3'd6,
        KIND_SACK   = 3'd7
    } kind_t;

    // sequencer state
    typedef struct packed {
        kind_t                  cmd;
        logic [STEP_W-1:0]      step;
        logic [BIT_IDX_W-1:0]   bit_idx;
        logic [DATA_BITS-1:0]   shift;
        logic [PHASE_W-1:0]     tick;
        logic                   scl;
        logic                   sda_drive;
        logic                   sda_level;
        logic                   ack;
        logic [DATA_BITS-1:0]   rdata;
    } seq_state_t;

    // configuration seen by the step logic
    typedef struct packed {
        logic [PHASE_W-1:0] phase_ticks;
        logic [HOLD_W-1:0]  rw_hold_ticks;
    } seq_cfg_t;

    // one result request
    typedef struct packed {
        logic                 rejected;
        logic                 ack_ok;
        logic [DATA_BITS-1:0] read_data;
        logic                 done_res;
        logic                 busy_res;
        logic                 sda_level;
        logic                 sda_drive;
        logic                 scl;
    } seq_result_t;

endpackage

[rtl/i2c_master_bit_sequencer.sv]
// i2c_master_bit_sequencer: top level of the i2c master bit sequencer
// request stage, step logic and result stage; depends on ims_pkg, ims_step_logic
// timing: an accepted request is held in the request register, then stepped into the
// result register once the result side is free; m_tready low stalls it
// throughput: one request per cycle while m_tready keeps the result side free, set by the
// combinational step logic between the request register and the result register
// reset: idle, scl high, sda released, phase_ticks 1, rw_hold_ticks 4
module i2c_master_bit_sequencer
(
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration writes
    input  logic                                cfg_we,
    input  logic [ims_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ims_pkg::CFG_DATA_W-1:0]      cfg_data,
    // request side
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [7:0] data_byte, [8] rw_bit, [9] sda_in, [15:10] zero
    input  logic [ims_pkg::IN_TDATA_W-1:0]      s_tdata,
    // [2:0] kind
    input  logic [ims_pkg::KIND_W-1:0]          s_tuser,
    // result side
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [0] scl, [1] sda_drive, [2] sda_level, [3] busy_res, [4] done_res,
    // [12:5] read_data, [13] ack_ok, [14] rejected, [15] zero
    output logic [ims_pkg::OUT_TDATA_W-1:0]     m_tdata
);

    logic                               in_valid_reg;
    ims_pkg::kind_t                     in_kind_reg;
    logic [ims_pkg::DATA_BITS-1:0]      in_data_reg;
    logic                               in_rw_reg;
    logic                               in_sda_reg;

    logic                               m_tvalid_reg;
    ims_pkg::seq_result_t               result_reg;

    ims_pkg::seq_state_t                state_reg;
    ims_pkg::seq_state_t                state_next;
    ims_pkg::seq_result_t               result_next;
    ims_pkg::seq_cfg_t                  cfg_reg;

    logic                               in_fire;
    logic                               proc_fire;

    // handshakes
    assign proc_fire = in_valid_reg && (!m_tvalid_reg || m_tready);
    assign s_tready  = !in_valid_reg || proc_fire;
    assign in_fire   = s_tvalid && s_tready;

    // step logic
    ims_step_logic u_step
    (
        .state      (state_reg),
        .cfg        (cfg_reg),
        .kind       (in_kind_reg),
        .data_byte  (in_data_reg),
        .rw_bit     (in_rw_reg),
        .sda_in     (in_sda_reg),
        .state_next (state_next),
        .result     (result_next)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.phase_ticks   <= ims_pkg::PHASE_TICKS_RESET;
            cfg_reg.rw_hold_ticks <= ims_pkg::RW_HOLD_TICKS_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                ims_pkg::CFG_PHASE_TICKS:
                    cfg_reg.phase_ticks <= cfg_data;
                ims_pkg::CFG_RW_HOLD_TICKS:
                    cfg_reg.rw_hold_ticks <= cfg_data[ims_pkg::HOLD_W-1:0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    // control: request valid, result valid, sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg        <= 1'b0;
            m_tvalid_reg        <= 1'b0;
            state_reg.cmd       <= ims_pkg::KIND_TICK;
            state_reg.step      <= '0;
            state_reg.bit_idx   <= '0;
            state_reg.shift     <= '0;
            state_reg.tick      <= '0;
            state_reg.scl       <= 1'b1;
            state_reg.sda_drive <= 1'b0;
            state_reg.sda_level <= 1'b1;
            state_reg.ack       <= 1'b0;
            state_reg.rdata     <= '0;
        end
        else
        begin
            if (in_fire)
                in_valid_reg <= 1'b1;
            else if (proc_fire)
                in_valid_reg <= 1'b0;

            if (proc_fire)
            begin
                m_tvalid_reg <= 1'b1;
                state_reg    <= state_next;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            in_kind_reg <= ims_pkg::kind_t'(s_tuser);
            in_data_reg <= s_tdata[ims_pkg::DATA_BITS-1:0];
            in_rw_reg   <= s_tdata[ims_pkg::DATA_BITS];
            in_sda_reg  <= s_tdata[ims_pkg::DATA_BITS+1];
        end
        if (proc_fire)
            result_reg <= result_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, result_reg};

endmodule

[rtl/ims_step_logic.sv]
// ims_step_logic: next-state and result logic for one request
// applies a command or a tick to the current bus sequencer state
// depends on ims_pkg
module ims_step_logic
(
    input  ims_pkg::seq_state_t                 state,
    input  ims_pkg::seq_cfg_t                   cfg,
    input  ims_pkg::kind_t                      kind,
    input  logic [ims_pkg::DATA_BITS-1:0]       data_byte,
    input  logic                                rw_bit,
    input  logic                                sda_in,
    output ims_pkg::seq_state_t                 state_next,
    output ims_pkg::seq_result_t                result
);

    // phases per bit for each command
    function automatic logic [2:0] steps_per_bit(input ims_pkg::kind_t c);
        case (c) inside
            ims_pkg::KIND_START, ims_pkg::KIND_STOP, ims_pkg::KIND_CHECK: return 3'd4;
            ims_pkg::KIND_WBYTE, ims_pkg::KIND_WADDR, ims_pkg::KIND_SACK: return 3'd3;
            ims_pkg::KIND_READ:                                           return 3'd2;
            default:                                                      return 3'd1;
        endcase
    endfunction

    // bits sent or received by each command
    function automatic logic [ims_pkg::BIT_IDX_W-1:0] bit_count(input ims_pkg::kind_t c);
        case (c) inside
            ims_pkg::KIND_WBYTE, ims_pkg::KIND_READ:
                return ims_pkg::BIT_IDX_W'(ims_pkg::DATA_BITS);
            ims_pkg::KIND_WADDR:
                return ims_pkg::BIT_IDX_W'(ims_pkg::ADDR_BITS + 1);
            default:
                return ims_pkg::BIT_IDX_W'(1);
        endcase
    endfunction

    // pin changes made on entry to a phase
    function automatic ims_pkg::seq_state_t enter_phase(input ims_pkg::seq_state_t s);
        ims_pkg::seq_state_t r;
        logic                b;
        r = s;
        // current bit, msb first
        b = s.shift[~s.bit_idx[2:0]];
        case (s.cmd) inside
            ims_pkg::KIND_START, ims_pkg::KIND_STOP:
            begin
                case (s.step)
                    2'd0: r.scl = 1'b0;
                    2'd1:
                    begin
                        r.sda_drive = 1'b1;
                        r.sda_level = (s.cmd == ims_pkg::KIND_START);
                    end
                    2'd2: r.scl = 1'b1;
                    default: r.sda_level = (s.cmd != ims_pkg::KIND_START);
                endcase
            end
            ims_pkg::KIND_WBYTE, ims_pkg::KIND_WADDR:
            begin
                case (s.step)
                    2'd0: r.scl = 1'b0;
                    2'd1:
                    begin
                        r.sda_drive = 1'b1;
                        r.sda_level = b;
                    end
                    2'd2: r.scl = 1'b1;
                    default: r.scl = s.scl;
                endcase
            end
            ims_pkg::KIND_CHECK:
            begin
                case (s.step)
                    2'd0, 2'd3: r.scl = 1'b0;
                    2'd1:       r.sda_drive = 1'b0;
                    default:    r.scl = 1'b1;
                endcase
            end
            ims_pkg::KIND_READ:
            begin
                if (s.step == 2'd0)
                begin
                    r.sda_drive = 1'b0;
                    r.scl       = 1'b1;
                end
                else
                begin
                    r.scl = 1'b0;
                end
            end
            ims_pkg::KIND_SACK:
            begin
                if (s.step == 2'd0)
                begin
                    r.sda_drive = 1'b1;
                    r.sda_level = 1'b0;
                end
                else
                begin
                    r.scl = (s.step == 2'd1);
                end
            end
            default:
                r = s;
        endcase
        return r;
    endfunction

    logic                              busy;
    logic                              in_rw_hold;
    logic [ims_pkg::PHASE_W-1:0]       tick_inc;
    logic [ims_pkg::PHASE_W-1:0]       hold_len;
    logic [2:0]                        step_inc;
    logic [ims_pkg::BIT_IDX_W-1:0]     bit_inc;
    logic [ims_pkg::BIT_IDX_W-1:0]     nbits;
    logic                              done;
    logic                              rejected;
    ims_pkg::seq_state_t               nx;

    assign busy       = (state.cmd != ims_pkg::KIND_TICK);
    assign in_rw_hold = (state.cmd == ims_pkg::KIND_WADDR) && (state.step == 2'd3);
    assign tick_inc   = state.tick + ims_pkg::PHASE_W'(1);
    assign nbits      = bit_count(state.cmd);

    // phase length: the read/write hold or the configured phase, a zero phase_ticks read as one
    always_comb
    begin
        if (in_rw_hold)
            hold_len = ims_pkg::PHASE_W'(cfg.rw_hold_ticks);
        else if (cfg.phase_ticks == '0)
            hold_len = ims_pkg::PHASE_W'(1);
        else
            hold_len = cfg.phase_ticks;
    end

    // command start, rejection of a command while busy, or phase advance
    always_comb
    begin
        nx       = state;
        done     = 1'b0;
        rejected = 1'b0;
        step_inc = {1'b0, state.step} + 3'd1;
        bit_inc  = state.bit_idx;
        if (kind != ims_pkg::KIND_TICK)
        begin
            if (busy)
            begin
                rejected = 1'b1;
            end
            else
            begin
                nx.cmd     = kind;
                nx.step    = '0;
                nx.bit_idx = '0;
                nx.tick    = '0;
                if (kind == ims_pkg::KIND_WADDR)
                    nx.shift = {data_byte[ims_pkg::ADDR_BITS-1:0], rw_bit};
                else
                    nx.shift = data_byte;
                if (kind == ims_pkg::KIND_READ)
                    nx.rdata = '0;
                nx = enter_phase(nx);
            end
        end
        else if (busy)
        begin
            if (tick_inc >= hold_len)
            begin
                nx.tick = '0;
                // sample sda at the end of the scl-high phase
                if (state.cmd == ims_pkg::KIND_CHECK && state.step == 2'd2)
                    nx.ack = ~sda_in;
                if (state.cmd == ims_pkg::KIND_READ && state.step == 2'd0)
                    nx.rdata = {state.rdata[ims_pkg::DATA_BITS-2:0], sda_in};
                // next phase, next bit or finish
                if (step_inc >= steps_per_bit(state.cmd))
                begin
                    if (!(state.cmd == ims_pkg::KIND_WADDR && step_inc == 3'd3
                          && (state.bit_idx + ims_pkg::BIT_IDX_W'(1)) == nbits
                          && cfg.rw_hold_ticks != '0))
                    begin
                        step_inc = 3'd0;
                        bit_inc  = state.bit_idx + ims_pkg::BIT_IDX_W'(1);
                        if (bit_inc >= nbits)
                            done = 1'b1;
                    end
                end
                if (done)
                begin
                    nx.cmd     = ims_pkg::KIND_TICK;
                    nx.step    = '0;
                    nx.bit_idx = '0;
                end
                else
                begin
                    nx.step    = step_inc[ims_pkg::STEP_W-1:0];
                    nx.bit_idx = bit_inc;
                    nx         = enter_phase(nx);
                end
            end
            else
            begin
                nx.tick = tick_inc;
            end
        end
    end

    assign state_next = nx;

    // result fields
    always_comb
    begin
        result.scl       = nx.scl;
        result.sda_drive = nx.sda_drive;
        result.sda_level = nx.sda_level;
        result.busy_res  = (nx.cmd != ims_pkg::KIND_TICK);
        result.done_res  = done;
        result.read_data = nx.rdata;
        result.ack_ok    = nx.ack;
        result.rejected  = rejected;
    end

endmodule
